@@ rtl/core/color_stop_fade_engine_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Color stop fade engine assertion macros
// Shared property wrappers for the concurrent checks in the engine's modules.
// ----------------------------------------------------------------------------
`ifndef COLOR_STOP_FADE_ENGINE_UNIT_ASSERT_SVH
`define COLOR_STOP_FADE_ENGINE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfe: check failed");

// The consequent must hold in the cycle after the antecedent.
`define CFE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfe: check failed");

`endif

@@ rtl/core/cfe_pkg.sv @@
// ----------------------------------------------------------------------------
// Color stop fade engine package
// Types, register codes and constants shared by the engine's modules.
// ----------------------------------------------------------------------------
package cfe_pkg;

   localparam int MAX_STOPS_DEF = 8;

   localparam logic [16:0] TICK_MS       = 17'd10;
   localparam logic [15:0] FADE_RESET    = 16'd1000;
   localparam logic [3:0]  COUNT_RESET   = 4'd2;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   localparam logic CSR_FADE_INTERVAL = 1'b0;
   localparam logic CSR_STOP_COUNT    = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [2:0] stop_index;
      logic [4:0] stop_brightness;
      logic [7:0] stop_red;
      logic [7:0] stop_green;
      logic [7:0] stop_blue;
   } req_type;

   typedef struct packed {
      logic [4:0] led_brightness;
      logic [7:0] led_red;
      logic [7:0] led_green;
      logic [7:0] led_blue;
   } rsp_type;

   typedef struct packed {
      logic [4:0] bri;
      logic [7:0] red;
      logic [7:0] grn;
      logic [7:0] blu;
   } stop_type;

   localparam int STOP_W = $bits(stop_type);

   typedef struct packed {
      logic        start;
      logic [7:0]  from_val;
      logic [7:0]  to_val;
      logic [15:0] t;
      logic [15:0] iv;
   } lerp_cmd_type;

   typedef struct packed {
      logic       done;
      logic [7:0] value;
   } lerp_sts_type;

endpackage

@@ rtl/core/cfe_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module cfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/cfe_lerp.sv @@
// ----------------------------------------------------------------------------
// Color stop fade engine interpolation unit
// Computes from + floor((to - from) * t / iv) for one 8-bit channel with one
// multiplier and a restoring divider that retires one quotient bit a cycle.
// ----------------------------------------------------------------------------
`include "color_stop_fade_engine_unit_assert.svh"

module cfe_lerp
   import cfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  lerp_cmd_type cmd,
   output lerp_sts_type sts
);

   localparam logic [1:0] LS_IDLE = 2'd0;
   localparam logic [1:0] LS_MUL  = 2'd1;
   localparam logic [1:0] LS_DIV  = 2'd2;
   localparam logic [1:0] LS_FIN  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [7:0]  val_ff, val_in;
   logic [7:0]  a_ff, a_in;
   logic [7:0]  mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [15:0] t_ff, t_in;
   logic [15:0] iv_ff, iv_in;
   logic [15:0] rem_ff, rem_in;
   logic [7:0]  quo_ff, quo_in;

   logic [23:0] prod;
   logic [16:0] shifted;
   logic [16:0] diff;
   logic        ge;
   logic [7:0]  corr;

   assign prod    = 24'(mag_ff) * 24'(t_ff);
   assign shifted = {rem_ff, quo_ff[7]};
   assign diff    = shifted - {1'b0, iv_ff};
   assign ge      = shifted >= {1'b0, iv_ff};
   assign corr    = quo_ff + {7'd0, (rem_ff != 16'd0)};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      val_in   = val_ff;
      a_in     = a_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      t_in     = t_ff;
      iv_in    = iv_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      unique case (state_ff)
         LS_IDLE: begin
            if (cmd.start) begin
               a_in   = cmd.from_val;
               neg_in = cmd.to_val < cmd.from_val;
               mag_in = (cmd.to_val < cmd.from_val) ? cmd.from_val - cmd.to_val
                                                    : cmd.to_val - cmd.from_val;
               t_in   = cmd.t;
               iv_in  = cmd.iv;
               if (cmd.iv == 16'd0) begin
                  // A zero interval holds the from value.
                  rem_in   = 16'd0;
                  quo_in   = 8'd0;
                  state_in = LS_FIN;
               end else begin
                  state_in = LS_MUL;
               end
            end
         end
         LS_MUL: begin
            rem_in   = prod[23:8];
            quo_in   = prod[7:0];
            cnt_in   = 3'd0;
            state_in = LS_DIV;
         end
         LS_DIV: begin
            rem_in = ge ? diff[15:0] : shifted[15:0];
            quo_in = {quo_ff[6:0], ge};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               state_in = LS_FIN;
            end
         end
         LS_FIN: begin
            val_in   = neg_ff ? a_ff - corr : a_ff + quo_ff;
            done_in  = 1'b1;
            state_in = LS_IDLE;
         end
         default: begin
            state_in = LS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      val_ff <= val_in;
      a_ff   <= a_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      t_ff   <= t_in;
      iv_ff  <= iv_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign sts.done  = done_ff;
   assign sts.value = val_ff;

   `CFE_ASSERT_SAME(a_rem_below_divisor, clock, reset, state_ff == LS_DIV, rem_ff < iv_ff)
   `CFE_ASSERT_SAME(a_start_when_idle, clock, reset, cmd.start, state_ff == LS_IDLE)
   `CFE_ASSERT_NEXT(a_finish_reports, clock, reset, state_ff == LS_FIN, sts.done)

endmodule

@@ rtl/core/color_stop_fade_engine_unit.sv @@
// A stop write leaves the engine idle, so the next beat can be accepted right after it.
// A tick reads its from- and to-stops, then runs the four channels in turn through the
// shared unit; its color is returned once the result register is free.
// No beat is taken until the tick's color has gone to the result register.
// Reset (synchronous, active high) empties the stop table, clears the timer and
// sets from-index 0, to-index 1, interval 1000 and stop count 2.
// ----------------------------------------------------------------------------
// Color stop fade engine
// Fades an LED color through a table of color stops, one interpolated color
// per tick, with a sequencer driving one shared interpolation unit.
// ----------------------------------------------------------------------------
`include "color_stop_fade_engine_unit_assert.svh"

module color_stop_fade_engine_unit
   import cfe_pkg::*;
#(
   parameter int MAX_STOPS = MAX_STOPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int IDX_W  = $clog2(MAX_STOPS);
   localparam int CMP_W  = (IDX_W + 1 > 4) ? IDX_W + 1 : 4;
   localparam int SLOT_W = (IDX_W + 1 > 3) ? IDX_W + 1 : 3;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_RD_TO   = 3'd1;
   localparam logic [2:0] ST_RD_WAIT = 3'd2;
   localparam logic [2:0] ST_LERP    = 3'd3;
   localparam logic [2:0] ST_WAIT    = 3'd4;
   localparam logic [2:0] ST_OUT     = 3'd5;

   localparam logic [1:0] CH_BRI = 2'd0;
   localparam logic [1:0] CH_RED = 2'd1;
   localparam logic [1:0] CH_GRN = 2'd2;
   localparam logic [1:0] CH_BLU = 2'd3;

   logic [2:0]           state_ff, state_in;
   logic [1:0]           ch_ff, ch_in;
   logic [15:0]          iv_ff, iv_in;
   logic [3:0]           count_ff, count_in;
   logic [16:0]          timer_ff, timer_in;
   logic [IDX_W-1:0]     from_ff, from_in;
   logic [IDX_W-1:0]     to_ff, to_in;
   logic [MAX_STOPS-1:0] valid_ff, valid_in;
   logic                 vld_rd_ff;
   logic [15:0]          t_ff, t_in;
   stop_type             from_stop_ff, from_stop_in;
   stop_type             to_stop_ff, to_stop_in;
   rsp_type              res_ff, res_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 req_fire;
   logic                 wr_en;
   logic [SLOT_W-1:0]    slot_wide;
   logic [IDX_W-1:0]     waddr;
   logic [IDX_W-1:0]     raddr;
   stop_type             wdata;
   stop_type             rdata;
   stop_type             rd_masked;
   logic                 out_free;
   logic [16:0]          timer_sum;
   logic [CMP_W-1:0]     used;
   logic [CMP_W-1:0]     to_next;
   lerp_cmd_type         lerp_cmd;
   lerp_sts_type         lerp_sts;

   assign req_ready = state_ff == ST_IDLE;
   assign req_fire  = req_valid && req_ready;
   assign slot_wide = SLOT_W'(req_data.stop_index);
   assign wr_en     = req_fire && (req_data.kind == KIND_WRITE)
                      && (slot_wide < SLOT_W'(MAX_STOPS));
   assign waddr     = slot_wide[IDX_W-1:0];
   assign raddr     = (state_ff == ST_IDLE) ? from_ff : to_ff;
   assign rd_masked = vld_rd_ff ? rdata : '0;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign timer_sum = timer_ff + TICK_MS;
   assign to_next   = CMP_W'(to_ff) + CMP_W'(1);

   assign wdata.bri = req_data.stop_brightness;
   assign wdata.red = req_data.stop_red;
   assign wdata.grn = req_data.stop_green;
   assign wdata.blu = req_data.stop_blue;

   cfe_ram #(
      .WIDTH (STOP_W),
      .DEPTH (MAX_STOPS)
   ) u_stop_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   cfe_lerp u_lerp (
      .clock (clock),
      .reset (reset),
      .cmd   (lerp_cmd),
      .sts   (lerp_sts)
   );

   always_comb begin
      used = CMP_W'(count_ff);
      if (used < CMP_W'(2)) begin
         used = CMP_W'(2);
      end
      if (used > CMP_W'(MAX_STOPS)) begin
         used = CMP_W'(MAX_STOPS);
      end
   end

   always_comb begin
      lerp_cmd.start = state_ff == ST_LERP;
      lerp_cmd.t     = t_ff;
      lerp_cmd.iv    = iv_ff;
      unique case (ch_ff)
         CH_BRI: begin
            lerp_cmd.from_val = {3'd0, from_stop_ff.bri};
            lerp_cmd.to_val   = {3'd0, to_stop_ff.bri};
         end
         CH_RED: begin
            lerp_cmd.from_val = from_stop_ff.red;
            lerp_cmd.to_val   = to_stop_ff.red;
         end
         CH_GRN: begin
            lerp_cmd.from_val = from_stop_ff.grn;
            lerp_cmd.to_val   = to_stop_ff.grn;
         end
         CH_BLU: begin
            lerp_cmd.from_val = from_stop_ff.blu;
            lerp_cmd.to_val   = to_stop_ff.blu;
         end
         default: begin
            lerp_cmd.from_val = from_stop_ff.blu;
            lerp_cmd.to_val   = to_stop_ff.blu;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      iv_in        = iv_ff;
      count_in     = count_ff;
      timer_in     = timer_ff;
      from_in      = from_ff;
      to_in        = to_ff;
      valid_in     = valid_ff;
      t_in         = t_ff;
      from_stop_in = from_stop_ff;
      to_stop_in   = to_stop_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_we) begin
         unique case (csr_index)
            CSR_FADE_INTERVAL: iv_in    = csr_wdata;
            CSR_STOP_COUNT:    count_in = csr_wdata[3:0];
            default:           iv_in    = iv_ff;
         endcase
      end

      if (wr_en) begin
         valid_in = valid_ff | (MAX_STOPS'(1) << waddr);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_data.kind == KIND_TICK)) begin
               t_in     = (timer_ff < {1'b0, iv_ff}) ? timer_ff[15:0] : iv_ff;
               state_in = ST_RD_TO;
            end
         end
         ST_RD_TO: begin
            from_stop_in = rd_masked;
            state_in     = ST_RD_WAIT;
         end
         ST_RD_WAIT: begin
            to_stop_in = rd_masked;
            ch_in      = CH_BRI;
            state_in   = ST_LERP;
         end
         ST_LERP: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (lerp_sts.done) begin
               unique case (ch_ff)
                  CH_BRI:  res_in.led_brightness = lerp_sts.value[4:0];
                  CH_RED:  res_in.led_red        = lerp_sts.value;
                  CH_GRN:  res_in.led_green      = lerp_sts.value;
                  CH_BLU:  res_in.led_blue       = lerp_sts.value;
                  default: res_in.led_blue       = lerp_sts.value;
               endcase
               if (ch_ff == CH_BLU) begin
                  state_in = ST_OUT;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = ST_LERP;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (timer_sum > {1'b0, iv_ff}) begin
                  // The fade is over: the to-stop becomes the from-stop.
                  timer_in = 17'd0;
                  from_in  = to_ff;
                  to_in    = (to_next >= used) ? '0 : to_next[IDX_W-1:0];
               end else begin
                  timer_in = timer_sum;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iv_ff        <= FADE_RESET;
         count_ff     <= COUNT_RESET;
         timer_ff     <= 17'd0;
         from_ff      <= '0;
         to_ff        <= IDX_W'(1);
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iv_ff        <= iv_in;
         count_ff     <= count_in;
         timer_ff     <= timer_in;
         from_ff      <= from_in;
         to_ff        <= to_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff        <= ch_in;
      vld_rd_ff    <= valid_ff[raddr];
      t_ff         <= t_in;
      from_stop_ff <= from_stop_in;
      to_stop_ff   <= to_stop_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CFE_ASSERT_SAME(a_done_while_waiting, clock, reset, lerp_sts.done, state_ff == ST_WAIT)
   `CFE_ASSERT_SAME(a_t_saturated, clock, reset, state_ff == ST_LERP, t_ff <= iv_ff)
   `CFE_ASSERT_NEXT(a_write_marks_valid, clock, reset, wr_en, valid_ff[$past(waddr)])

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Color stop fade engine testbench
// Drives stop writes and ticks into the engine with random gaps on both sides
// and compares every color beat against an in-bench predictor of the fade.
// ----------------------------------------------------------------------------
module tb
   import cfe_pkg::*;
();

   localparam int STOPS        = MAX_STOPS_DEF;
   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_CYCLES  = 900;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 1700;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we    = 1'b0;
   logic        csr_index = CSR_FADE_INTERVAL;
   logic [15:0] csr_wdata = '0;

   stop_type    palette [STOPS];
   logic [16:0] fade_ms;
   logic [2:0]  src_slot;
   logic [2:0]  dst_slot;
   logic [15:0] interval_ms;
   logic [3:0]  count_reg;
   rsp_type     expected_colors [$];

   int errors         = 0;
   int writes_sent    = 0;
   int ticks_sent     = 0;
   int colors_checked = 0;
   int settings_used  = 0;
   int cycles         = 0;
   int tx_burst       = 0;
   int rx_burst       = 0;
   bit hold_req       = 1'b0;

   color_stop_fade_engine_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [7:0] blend(logic [7:0] a, logic [7:0] b, logic [15:0] t,
                                        logic [15:0] iv);
      longint av, bv, tv, ivl, n, q, r;
      av  = longint'(a);
      bv  = longint'(b);
      tv  = longint'(t);
      ivl = longint'(iv);
      if (iv == 16'd0) return a;
      n = (bv - av) * tv;
      if (n >= 0) q = n / ivl;
      else q = -((-n + ivl - 1) / ivl);
      r = av + q;
      return r[7:0];
   endfunction

   function automatic void take_beat(req_type r);
      stop_type    a;
      stop_type    b;
      logic [15:0] t;
      logic [7:0]  bri8;
      rsp_type     c;
      int          used;
      int          nxt;
      if (r.kind == KIND_WRITE) begin
         palette[r.stop_index].bri = r.stop_brightness;
         palette[r.stop_index].red = r.stop_red;
         palette[r.stop_index].grn = r.stop_green;
         palette[r.stop_index].blu = r.stop_blue;
         writes_sent++;
         return;
      end
      a = palette[src_slot];
      b = palette[dst_slot];
      t = (fade_ms < {1'b0, interval_ms}) ? fade_ms[15:0] : interval_ms;
      bri8 = blend({3'b000, a.bri}, {3'b000, b.bri}, t, interval_ms);
      c.led_brightness = bri8[4:0];
      c.led_red        = blend(a.red, b.red, t, interval_ms);
      c.led_green      = blend(a.grn, b.grn, t, interval_ms);
      c.led_blue       = blend(a.blu, b.blu, t, interval_ms);
      expected_colors.push_back(c);
      fade_ms = fade_ms + TICK_MS;
      if (fade_ms > {1'b0, interval_ms}) begin
         fade_ms  = '0;
         src_slot = dst_slot;
         used     = (count_reg < 4'd2) ? 2 : ((count_reg > STOPS) ? STOPS : count_reg);
         nxt      = dst_slot + 1;
         dst_slot = (nxt >= used) ? 3'd0 : nxt[2:0];
      end
      ticks_sent++;
   endfunction

   function automatic req_type random_beat(logic kind);
      logic [63:0] raw;
      req_type     r;
      raw    = {$urandom, $urandom};
      r      = raw[$bits(req_type)-1:0];
      r.kind = kind;
      return r;
   endfunction

   task automatic send_beat(req_type r);
      int gap;
      if (tx_burst > 0) begin
         tx_burst--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 14);
         if ($urandom_range(0, 19) == 0) tx_burst = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      take_beat(r);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FADE_INTERVAL) interval_ms = value;
      else count_reg = value[3:0];
      settings_used++;
      @(posedge clock);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (rx_burst > 0) begin
            rx_burst--;
            stall = 0;
         end else begin
            stall = $urandom_range(0, 14);
            if ($urandom_range(0, 19) == 0) rx_burst = $urandom_range(10, 40);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_colors.size() == 0) begin
            $error("color beat with no expected color: %h", rsp_data);
            errors++;
         end else begin
            want = expected_colors.pop_front();
            check_field("led_brightness", int'(want.led_brightness),
                        int'(rsp_data.led_brightness));
            check_field("led_red", int'(want.led_red), int'(rsp_data.led_red));
            check_field("led_green", int'(want.led_green), int'(rsp_data.led_green));
            check_field("led_blue", int'(want.led_blue), int'(rsp_data.led_blue));
            colors_checked++;
         end
      end
   end

   task automatic test_stop_write_extremes();
      req_type r;
      for (int slot = 0; slot < STOPS; slot++) begin
         r = random_beat(KIND_WRITE);
         r.stop_index      = 3'(slot);
         r.stop_brightness = {5{r.stop_index[0]}};
         r.stop_red        = {8{r.stop_index[1]}};
         r.stop_green      = {8{r.stop_index[2]}};
         r.stop_blue       = {8{~r.stop_index[0]}};
         send_beat(r);
      end
   endtask

   task automatic test_zero_interval_wrap();
      wait_idle();
      write_reg(CSR_FADE_INTERVAL, 16'd0);
      write_reg(CSR_STOP_COUNT, 16'hFFFF);
      repeat (10) send_beat(random_beat(KIND_TICK));
   endtask

   task automatic test_short_count();
      wait_idle();
      write_reg(CSR_STOP_COUNT, 16'h0000);
      repeat (3) send_beat(random_beat(KIND_TICK));
   endtask

   task automatic test_interval_cut();
      wait_idle();
      write_reg(CSR_FADE_INTERVAL, 16'd1000);
      repeat (3) send_beat(random_beat(KIND_TICK));
      wait_idle();
      write_reg(CSR_FADE_INTERVAL, 16'd10);
      repeat (2) send_beat(random_beat(KIND_TICK));
   endtask

   task automatic test_output_backpressure();
      hold_req = 1'b1;
      repeat (24) send_beat(random_beat(KIND_TICK));
   endtask

   task automatic test_random_fades();
      int          sent;
      int          len;
      logic [15:0] iv;
      req_type     r;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         case ($urandom_range(0, 9))
            0: iv = 16'd0;
            1: iv = 16'hFFFF;
            2: iv = 16'($urandom);
            default: iv = 16'($urandom_range(10, 200));
         endcase
         write_reg(CSR_FADE_INTERVAL, iv);
         if ($urandom_range(0, 3) != 0) write_reg(CSR_STOP_COUNT, 16'($urandom));
         if ($urandom_range(0, 1) == 1) begin
            for (int slot = 0; slot < STOPS; slot++) begin
               r = random_beat(KIND_WRITE);
               r.stop_index = 3'(slot);
               send_beat(r);
            end
            sent += STOPS;
         end
         len = $urandom_range(40, 120);
         repeat (len) begin
            if ($urandom_range(0, 6) == 0) r = random_beat(KIND_WRITE);
            else r = random_beat(KIND_TICK);
            send_beat(r);
         end
         sent += len;
      end
   endtask

   initial begin
      for (int i = 0; i < STOPS; i++) palette[i] = '0;
      fade_ms     = '0;
      src_slot    = 3'd0;
      dst_slot    = 3'd1;
      interval_ms = FADE_RESET;
      count_reg   = COUNT_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_stop_write_extremes();
      test_zero_interval_wrap();
      test_short_count();
      test_interval_cut();
      test_output_backpressure();
      test_random_fades();
      wait_idle();

      if (expected_colors.size() != 0) begin
         $error("%0d expected colors never arrived", expected_colors.size());
         errors++;
      end
      $display("Sent %0d stop writes and %0d ticks over %0d register writes.",
               writes_sent, ticks_sent, settings_used);
      $display("Compared %0d color beats with %0d mismatches.", colors_checked, errors);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
